@@ rtl/lfu_kv_pkg.sv @@
package lfu_kv_pkg;

  localparam int unsigned MaxEntriesDefault = 16;
  localparam int unsigned KeyW   = 32;
  localparam int unsigned DataW  = 32;
  localparam int unsigned CountW = 32;
  localparam int unsigned CfgW   = 5;

  localparam logic [CfgW-1:0] CapacityReset = 5'd16;

  localparam logic ModeGet = 1'b0;
  localparam logic ModePut = 1'b1;

  typedef struct packed {
    logic                    mode;
    logic signed [KeyW-1:0]  key;
    logic signed [DataW-1:0] write_value;
  } cache_req_t;

  typedef struct packed {
    logic                    hit;
    logic signed [DataW-1:0] read_value;
    logic                    evicted;
    logic signed [KeyW-1:0]  evicted_key;
  } cache_rsp_t;

  // one stored line: key, value and use count share a RAM word
  typedef struct packed {
    logic [KeyW-1:0]   key;
    logic [DataW-1:0]  value;
    logic [CountW-1:0] count;
  } entry_t;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StLast,
    StDecide
  } state_e;

endpackage

@@ rtl/lfu_key_value_cache_unit.sv @@
// Key-value cache, least-frequently-used replacement, oldest entry first on equal counts.
// Request: drive req_i (mode, key, write_value) and raise start; the transfer
// happens at a rising edge with start high and busy low. busy stays high until the
// result is out. Each request gives exactly one result: result_valid_o is high for
// one cycle with rsp_o (hit, read_value, evicted, evicted_key). The receiver cannot
// stall, so the result must be taken in that cycle.
// Sequence per request: one pass over the entry RAM, one entry per cycle through
// its single read port with registered read data, then a drain state (StLast),
// an update state (StDecide) and the result, at which busy is already low again.
// A new request may be started in the same cycle the result strobe is high.
// Capacity: written through cfg_we_i / cfg_wdata_i, which the user must do only while
// idle (not enforced); values above MaxEntries act as MaxEntries, zero stops stores.
// Reset: all entries invalid, capacity 16, no clearing pass (the RAM is only read
// behind valid bits), so a request may be started in the first cycle after reset.
module lfu_key_value_cache_unit #(
  parameter int unsigned MaxEntries = lfu_kv_pkg::MaxEntriesDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  lfu_kv_pkg::cache_req_t          req_i,
  output logic                            result_valid_o,
  output lfu_kv_pkg::cache_rsp_t          rsp_o,
  input  logic                            cfg_we_i,
  input  logic [lfu_kv_pkg::CfgW-1:0]     cfg_wdata_i
);
  import lfu_kv_pkg::*;

  localparam int unsigned IdxW  = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
  localparam int unsigned RankW = IdxW;
  localparam int unsigned NumW  = $clog2(MaxEntries + 1);
  localparam int unsigned CapW  = (NumW > CfgW) ? NumW : CfgW;
  localparam int unsigned EntW  = $bits(entry_t);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(MaxEntries - 1);
  localparam logic [CapW-1:0] CapMax  = CapW'(MaxEntries);

  state_e state_q, state_d;

  logic              accept, scan_rd, decide;
  logic [CfgW-1:0]   cap_q;
  cache_req_t        req_q;
  logic [IdxW-1:0]   addr_q;
  logic              chk_q;
  logic [IdxW-1:0]   pidx_q;

  // scan results
  logic [NumW-1:0]   stored_q;
  logic              found_q;
  logic [IdxW-1:0]   fidx_q;
  logic [DataW-1:0]  fval_q;
  logic [CountW-1:0] fcnt_q;
  logic [RankW-1:0]  frank_q;
  logic              free_q;
  logic [IdxW-1:0]   free_idx_q;
  logic              vict_q;
  logic [IdxW-1:0]   vidx_q;
  logic [KeyW-1:0]   vkey_q;
  logic [CountW-1:0] vcnt_q;
  logic [RankW-1:0]  vrank_q;

  logic [MaxEntries-1:0] valid_q, valid_d;
  logic [RankW-1:0]      rank_q [MaxEntries];
  logic [RankW-1:0]      rank_d [MaxEntries];

  logic              rv_q;
  cache_rsp_t        rsp_q, rsp_d;

  entry_t            ent;
  logic [EntW-1:0]   ram_rdata;
  logic              ram_we;
  logic [IdxW-1:0]   ram_waddr;
  entry_t            ram_wdata;

  logic              cur_valid;
  logic [RankW-1:0]  cur_rank;
  logic              take_match, take_free, take_vict;

  logic [CapW-1:0]   cap_eff;
  logic              cap_zero, is_put, full;
  logic              do_touch, do_insert, do_evict;
  logic [IdxW-1:0]   slot;
  logic [CountW-1:0] fcnt_inc;

  // ---------------- sequencer ----------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (start) state_d = StScan;
      end
      StScan: begin
        if (addr_q == LastIdx) state_d = StLast;
      end
      StLast:   state_d = StDecide;
      StDecide: state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  always_comb begin
    busy    = 1'b1;
    scan_rd = 1'b0;
    decide  = 1'b0;
    case (state_q)
      StIdle:   busy    = 1'b0;
      StScan:   scan_rd = 1'b1;
      StLast:   ;
      StDecide: decide  = 1'b1;
      default:  busy    = 1'b1;
    endcase
  end

  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cap_q   <= CapacityReset;
      chk_q   <= 1'b0;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      chk_q   <= scan_rd;
      rv_q    <= decide;
      if (cfg_we_i) cap_q <= cfg_wdata_i;
    end
  end

  // ---------------- entry RAM ----------------
  lfu_kv_ram #(
    .Width (EntW),
    .Depth (MaxEntries)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (addr_q),
    .rdata_o (ram_rdata)
  );

  assign ent = entry_t'(ram_rdata);

  // ---------------- scan: one entry per cycle ----------------
  assign cur_valid = valid_q[pidx_q];
  assign cur_rank  = rank_q[pidx_q];

  assign take_match = chk_q && cur_valid && !found_q && (ent.key == req_q.key);
  assign take_free  = chk_q && !cur_valid && !free_q;
  // lowest count wins, larger rank (older) on equal counts
  assign take_vict  = chk_q && cur_valid &&
                      (!vict_q || (ent.count < vcnt_q) ||
                       ((ent.count == vcnt_q) && (cur_rank > vrank_q)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q  <= 1'b0;
      free_q   <= 1'b0;
      vict_q   <= 1'b0;
      stored_q <= '0;
    end else if (accept) begin
      found_q  <= 1'b0;
      free_q   <= 1'b0;
      vict_q   <= 1'b0;
      stored_q <= '0;
    end else begin
      if (take_match) found_q <= 1'b1;
      if (take_free)  free_q  <= 1'b1;
      if (take_vict)  vict_q  <= 1'b1;
      if (chk_q && cur_valid) stored_q <= stored_q + NumW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q  <= req_i;
      addr_q <= '0;
    end else if (scan_rd) begin
      addr_q <= addr_q + IdxW'(1);
    end
    pidx_q <= addr_q;
    if (take_match) begin
      fidx_q  <= pidx_q;
      fval_q  <= ent.value;
      fcnt_q  <= ent.count;
      frank_q <= cur_rank;
    end
    if (take_free) free_idx_q <= pidx_q;
    if (take_vict) begin
      vidx_q  <= pidx_q;
      vkey_q  <= ent.key;
      vcnt_q  <= ent.count;
      vrank_q <= cur_rank;
    end
  end

  // ---------------- update ----------------
  assign cap_eff  = (CapW'(cap_q) > CapMax) ? CapMax : CapW'(cap_q);
  assign cap_zero = (cap_q == '0);
  assign is_put   = (req_q.mode == ModePut);
  assign full     = (CapW'(stored_q) >= cap_eff);

  assign do_touch  = found_q && (!is_put || !cap_zero);
  assign do_insert = !found_q && is_put && !cap_zero && (full ? vict_q : free_q);
  assign do_evict  = do_insert && full;
  assign slot      = full ? vidx_q : free_idx_q;
  assign fcnt_inc  = (fcnt_q == '1) ? fcnt_q : fcnt_q + CountW'(1);

  always_comb begin
    ram_we    = decide && (do_touch || do_insert);
    ram_waddr = do_touch ? fidx_q : slot;
    ram_wdata.key = req_q.key;
    if (do_touch) begin
      ram_wdata.value = is_put ? req_q.write_value : fval_q;
      ram_wdata.count = fcnt_inc;
    end else begin
      ram_wdata.value = req_q.write_value;
      ram_wdata.count = CountW'(1);
    end
  end

  always_comb begin
    for (int j = 0; j < MaxEntries; j++) begin
      rank_d[j]  = rank_q[j];
      valid_d[j] = valid_q[j];
      if (decide && do_touch) begin
        if (IdxW'(j) == fidx_q) begin
          rank_d[j] = '0;
        end else if (valid_q[j] && (rank_q[j] < frank_q)) begin
          rank_d[j] = rank_q[j] + RankW'(1);
        end
      end else if (decide && do_insert) begin
        if (IdxW'(j) == slot) begin
          rank_d[j]  = '0;
          valid_d[j] = 1'b1;
        end else if (valid_q[j]) begin
          // entries older than the victim close the gap, then all age by one
          if (do_evict && (rank_q[j] > vrank_q)) rank_d[j] = rank_q[j];
          else rank_d[j] = rank_q[j] + RankW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < MaxEntries; j++) begin
      rank_q[j] <= rank_d[j];
    end
  end

  always_comb begin
    rsp_d.hit         = found_q;
    rsp_d.read_value  = (found_q && !is_put) ? fval_q : '0;
    rsp_d.evicted     = do_evict;
    rsp_d.evicted_key = do_evict ? vkey_q : '0;
  end

  always_ff @(posedge clk_i) begin
    if (decide) rsp_q <= rsp_d;
  end

  assign result_valid_o = rv_q;
  assign rsp_o          = rsp_q;

  // ---------------- assertions ----------------
  a_result_after_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(state_q == StDecide))
    else $error("result strobe without update cycle");

  a_start_enters_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (state_q == StScan))
    else $error("accepted request did not start a scan");

  a_evict_only_on_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && rsp_o.evicted) |-> !rsp_o.hit)
    else $error("eviction reported on a hit");

  a_free_slot_is_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (decide && do_insert && !full) |-> !valid_q[free_idx_q])
    else $error("insert into an occupied entry");

  a_stored_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    decide |-> ($countones(valid_q) == int'(stored_q)))
    else $error("scan count disagrees with valid bits");

endmodule

@@ rtl/lfu_kv_ram.sv @@
module lfu_kv_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                          wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                          rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
